// ===== rtl/mmt_pkg.sv =====
// Shared types, constants and the CRC-16 helper for the Modbus RTU
// master transaction block. No dependencies.
`timescale 1ns / 1ps

package mmt_pkg;

  localparam int MAX_FRAME_BYTES = 256;
  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_BYTE  = 2'd2;
  localparam logic [1:0] ACT_END   = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_TIMEOUT = 3'd1;
  localparam logic [2:0] ST_CRC     = 3'd2;
  localparam logic [2:0] ST_EXCEPT  = 3'd3;
  localparam logic [2:0] ST_TURN    = 3'd4;

  localparam logic [1:0] CFG_TURNAROUND = 2'd0;
  localparam logic [1:0] CFG_READ_TO    = 2'd1;
  localparam logic [1:0] CFG_WRITE_TO   = 2'd2;

  localparam logic [7:0]  FC_WRITE_SINGLE = 8'd6;
  localparam logic [7:0]  FC_WRITE_MULTI  = 8'd16;
  localparam logic [7:0]  FUNC_MASK       = 8'h7F;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  reply_id;
    logic [7:0]  reply_function;
    logic [7:0]  exception_code;
    logic [8:0]  frame_length;
  } result_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

// ===== rtl/mmt_core.sv =====
// Transaction state, timer, receive buffer and CRC check.
// Produces at most one result per accepted request. Depends on mmt_pkg.
`timescale 1ns / 1ps

module mmt_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_wdata,
  input  logic              fire,
  input  logic [1:0]        action,
  input  logic [7:0]        slave_id,
  input  logic [7:0]        function_code,
  input  logic [7:0]        rx_byte,
  output logic              res_valid,
  output mmt_pkg::result_t  res
);
  import mmt_pkg::*;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_TURN = 2'd1;
  localparam logic [1:0] MODE_WAIT = 2'd2;

  logic [15:0]      turn_r, read_to_r, write_to_r;
  logic [1:0]       mode_r, mode_nxt;
  logic [15:0]      timer_r, timer_nxt;
  logic [7:0]       target_r, target_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       cap0_r, cap1_r, cap2_r;
  logic [7:0]       cap0_nxt, cap1_nxt, cap2_nxt;
  logic [15:0]      timer_dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_r     <= 16'd100;
      read_to_r  <= 16'd1000;
      write_to_r <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TURNAROUND: turn_r     <= cfg_wdata;
        CFG_READ_TO:    read_to_r  <= cfg_wdata;
        CFG_WRITE_TO:   write_to_r <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  assign timer_dec = (timer_r != 16'd0) ? timer_r - 16'd1 : 16'd0;

  always_comb begin
    mode_nxt   = mode_r;
    timer_nxt  = timer_r;
    target_nxt = target_r;
    crc_nxt    = crc_r;
    cnt_nxt    = cnt_r;
    cap0_nxt   = cap0_r;
    cap1_nxt   = cap1_r;
    cap2_nxt   = cap2_r;
    res_valid  = 1'b0;
    res.status         = ST_OK;
    res.reply_id       = cap0_r;
    res.reply_function = cap1_r & FUNC_MASK;
    res.exception_code = cap2_r;
    res.frame_length   = 9'(cnt_r);
    if (fire) begin
      case (action)
        ACT_TICK: begin
          if (mode_r != MODE_IDLE) begin
            timer_nxt = timer_dec;
            if (timer_dec == 16'd0) begin
              mode_nxt  = MODE_IDLE;
              res_valid = 1'b1;
              if (mode_r == MODE_TURN) begin
                res.status         = ST_TURN;
                res.reply_id       = 8'd0;
                res.reply_function = 8'd0;
                res.exception_code = 8'd0;
                res.frame_length   = 9'd0;
              end else begin
                res.status = ST_TIMEOUT;
              end
            end
          end
        end
        ACT_START: begin
          if (mode_r == MODE_IDLE) begin
            target_nxt = slave_id;
            crc_nxt    = CRC_INIT;
            cnt_nxt    = '0;
            cap0_nxt   = 8'd0;
            cap1_nxt   = 8'd0;
            cap2_nxt   = 8'd0;
            if (slave_id == 8'd0) begin
              timer_nxt = turn_r;
              mode_nxt  = MODE_TURN;
            end else begin
              timer_nxt = (function_code == FC_WRITE_SINGLE ||
                           function_code == FC_WRITE_MULTI) ? write_to_r : read_to_r;
              mode_nxt  = MODE_WAIT;
            end
          end
        end
        ACT_BYTE: begin
          if (mode_r == MODE_WAIT && cnt_r < CNT_W'(MAX_FRAME_BYTES)) begin
            if (cnt_r == CNT_W'(0)) cap0_nxt = rx_byte;
            if (cnt_r == CNT_W'(1)) cap1_nxt = rx_byte;
            if (cnt_r == CNT_W'(2)) cap2_nxt = rx_byte;
            crc_nxt = crc_update(crc_r, rx_byte);
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        ACT_END: begin
          if (mode_r == MODE_WAIT) begin
            if (cnt_r == CNT_W'(0) || cap0_r != target_r) begin
              crc_nxt  = CRC_INIT;
              cnt_nxt  = '0;
              cap0_nxt = 8'd0;
              cap1_nxt = 8'd0;
              cap2_nxt = 8'd0;
            end else begin
              mode_nxt  = MODE_IDLE;
              res_valid = 1'b1;
              if (crc_r != 16'd0) begin
                res.status = ST_CRC;
              end else if (cap1_r[7]) begin
                res.status = ST_EXCEPT;
              end else begin
                res.status         = ST_OK;
                res.reply_function = cap1_r;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      timer_r  <= 16'd0;
      target_r <= 8'd0;
      crc_r    <= CRC_INIT;
      cnt_r    <= '0;
      cap0_r   <= 8'd0;
      cap1_r   <= 8'd0;
      cap2_r   <= 8'd0;
    end else begin
      mode_r   <= mode_nxt;
      timer_r  <= timer_nxt;
      target_r <= target_nxt;
      crc_r    <= crc_nxt;
      cnt_r    <= cnt_nxt;
      cap0_r   <= cap0_nxt;
      cap1_r   <= cap1_nxt;
      cap2_r   <= cap2_nxt;
    end
  end

  a_res_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> fire) else $error("result without accepted request");
  a_res_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> mode_r == MODE_IDLE) else $error("block not idle after result");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_FRAME_BYTES)) else $error("byte count past maximum");
  a_turn_result_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && mode_r == MODE_TURN) |-> (res.status == ST_TURN && res.frame_length == 9'd0))
    else $error("turnaround result carries frame data");
  a_idle_no_timer_move: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_IDLE && !(fire && action == ACT_START)) |=> $stable(timer_r))
    else $error("timer moved while idle");

endmodule

// ===== rtl/mmt_out_buf.sv =====
// Two-entry result buffer between the transaction core and the result
// channel. Depends on mmt_pkg.
`timescale 1ns / 1ps

module mmt_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mmt_pkg::result_t  din,
  output logic              has_room,
  output logic              out_valid,
  input  logic              out_ready,
  output mmt_pkg::result_t  dout
);
  import mmt_pkg::*;

  result_t    s0_r, s0_nxt, s1_r, s1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign has_room  = (cnt_r != 2'd2);
  assign pop       = out_valid && out_ready;
  assign dout      = s0_r;

  always_comb begin
    s0_nxt  = s0_r;
    s1_nxt  = s1_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      if (cnt_r == 2'd0) s0_nxt = din;
      else               s1_nxt = din;
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      s0_nxt  = s1_r;
      cnt_nxt = cnt_r - 2'd1;
    end else if (push && pop) begin
      if (cnt_r == 2'd1) begin
        s0_nxt = din;
      end else begin
        s0_nxt = s1_r;
        s1_nxt = din;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= 2'd0;
    else        cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    s0_r <= s0_nxt;
    s1_r <= s1_nxt;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (has_room || pop)) else $error("push into full buffer");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("buffer count out of range");
  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> cnt_r == $past(cnt_r) - 2'd1) else $error("pop lost");

endmodule

// ===== rtl/modbus_master_transaction_fsm.sv =====
// Top level of the Modbus RTU master transaction controller.
// Instantiates mmt_core and mmt_out_buf; depends on mmt_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one event per request: a tick,
//   a request start (slave id, function code), a received byte or a frame end.
//   Result channel (out_valid/out_ready) carries status, the first three
//   captured bytes and the frame length, at most one result per request.
//   Configuration: cfg_we with cfg_index 0 turnaround, 1 read timeout,
//   2 write timeout; write only while no result is outstanding.
//   Throughput: one request per cycle while in_ready is high. All work for a
//   request is done in the cycle it is accepted; its result is registered.
//   A two-entry result buffer keeps in_ready high while one result waits;
//   in_ready is low while two results are held, which takes a stalled receiver.
//   Reset (rst_n low, synchronous) returns to idle, loads the register
//   defaults (100, 1000, 1000) and empties the result buffer.
`timescale 1ns / 1ps

module modbus_master_transaction_fsm (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_slave_id,
  input  logic [7:0]  in_function_code,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [7:0]  out_reply_id,
  output logic [7:0]  out_reply_function,
  output logic [7:0]  out_exception_code,
  output logic [8:0]  out_frame_length
);
  import mmt_pkg::*;

  logic    fire;
  logic    res_valid;
  result_t res;
  result_t dout;

  assign fire = in_valid && in_ready;

  mmt_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fire          (fire),
    .action        (in_action),
    .slave_id      (in_slave_id),
    .function_code (in_function_code),
    .rx_byte       (in_rx_byte),
    .res_valid     (res_valid),
    .res           (res)
  );

  mmt_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .din       (res),
    .has_room  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (dout)
  );

  assign out_status         = dout.status;
  assign out_reply_id       = dout.reply_id;
  assign out_reply_function = dout.reply_function;
  assign out_exception_code = dout.exception_code;
  assign out_frame_length   = dout.frame_length;

endmodule
